// File: sv/tfm_pkg.sv
// ----------------------------------------------------------------------------
// tfm_pkg: shared types and constants for the two-queue merge arbiter
// Word layouts, function and status codes, and queue sizes that do not vary.
// ----------------------------------------------------------------------------
`default_nettype none

package tfm_pkg;

    localparam int ID_W      = 16;
    localparam int STAMP_W   = 6;
    localparam int ENTRY_W   = ID_W + STAMP_W;
    localparam int FUNC_W    = 2;
    localparam int SEL_W     = 2;
    localparam int MODE_W    = 2;
    localparam int CNT_W     = 6;
    localparam int STATUS_W  = 3;
    localparam int CAP_W     = 5;

    localparam logic [CAP_W-1:0] CAP_RESET   = 5'd16;
    localparam logic [CNT_W-1:0] MAX_RESULTS = 6'd32;

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_JOIN  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SERVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_HIST  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_BAD   = 2'd3;

    // queue select and serve mode codes
    localparam logic [SEL_W-1:0]  SEL_ONE    = 2'd1;
    localparam logic [SEL_W-1:0]  SEL_TWO    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MERGE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALT   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_JOINED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SERVED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HIST   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE   = 3'd4;

    // command and result queue sizes
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

    typedef enum logic [1:0] {
        K_JOIN  = 2'd0,
        K_SERVE = 2'd1,
        K_HIST  = 2'd2,
        K_NONE  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   cid;
        logic [SEL_W-1:0]  sel;
        logic [MODE_W-1:0] mode;
        logic [CNT_W-1:0]  n;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [STAMP_W-1:0]  stamp;
        logic                last;
    } res_t;

endpackage

`default_nettype wire

// File: sv/two_fifo_merge_arbiter.sv
// ----------------------------------------------------------------------------
// two_fifo_merge_arbiter: two-queue merge arbiter, top level
// Joins, drains and history reads over two bounded entry queues.
// ----------------------------------------------------------------------------
// Input words go in through push/full and result words come out through
// empty/pop; each input word yields one or more result words and the final
// one carries last. Inputs land in a two-word command queue, so input words
// are taken one per cycle while that queue has room. The execution side runs
// one command at a time: a join or any single-result command finishes in the
// idle state, a serve drains one entry per result word, and a history read
// alternates a read state and a write state per returned entry (the history
// memory has a registered read port), with a trailing "empty" word if the
// history runs out first. Results go through a two-word result queue, so a
// stalled consumer only blocks execution once that queue fills. line_capacity
// is written over the cfg port (always ready) and must only change while the
// block is idle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module two_fifo_merge_arbiter
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int HIST_DEPTH  = 32
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input word channel
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [tfm_pkg::FUNC_W-1:0]   func,
    input  wire logic [tfm_pkg::ID_W-1:0]     customer_id,
    input  wire logic [tfm_pkg::SEL_W-1:0]    line_select,
    input  wire logic [tfm_pkg::MODE_W-1:0]   serve_mode,
    input  wire logic [tfm_pkg::CNT_W-1:0]    history_count,
    // result word channel
    output logic                              empty,
    input  wire logic                         pop,
    output logic [tfm_pkg::STATUS_W-1:0]      status,
    output logic [tfm_pkg::ID_W-1:0]          out_id,
    output logic [tfm_pkg::STAMP_W-1:0]       out_stamp,
    output logic                              last,
    // configuration
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [tfm_pkg::CAP_W-1:0]    cfg_data
);

    logic [tfm_pkg::CAP_W-1:0] line_capacity_reg;
    logic                      cmd_valid;
    tfm_pkg::cmd_t             cmd;
    logic                      cmd_pop;
    logic                      res_full;
    logic                      res_push;
    tfm_pkg::res_t             res_wdata;
    tfm_pkg::res_t             res_rdata;

    // configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_capacity_reg <= tfm_pkg::CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            line_capacity_reg <= cfg_data;
        end
    end

    // front: decode and command queue
    tfm_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .func          (func),
        .customer_id   (customer_id),
        .line_select   (line_select),
        .serve_mode    (serve_mode),
        .history_count (history_count),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    // back: queues, drain sequencer, history stack
    tfm_back
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HIST_DEPTH  (HIST_DEPTH)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .line_capacity (line_capacity_reg),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .res_full      (res_full),
        .res_push      (res_push),
        .res_data      (res_wdata)
    );

    // result queue
    tfm_resq u_resq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .empty (empty),
        .pop   (pop),
        .rdata (res_rdata)
    );

    assign status    = res_rdata.status;
    assign out_id    = res_rdata.id;
    assign out_stamp = res_rdata.stamp;
    assign last      = res_rdata.last;

    // execution never writes a word into a full result queue
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result word pushed into full result queue");

    // a command is only taken when one is waiting
    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> cmd_valid)
        else $error("command popped from empty command queue");

    // join results are always single words
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && ((status == tfm_pkg::ST_JOINED) || (status == tfm_pkg::ST_REJECT)))
        |-> last)
        else $error("join result without last");

    // a drain moves at most 32 entries, so a served word's number stays below 32
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == tfm_pkg::ST_SERVED)) |-> (out_stamp < 6'd32))
        else $error("service number out of range");

endmodule

`default_nettype wire

// File: sv/tfm_front.sv
// ----------------------------------------------------------------------------
// tfm_front: input decode and command queue
// Classifies each accepted word into a command and holds it in a short FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

module tfm_front
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [tfm_pkg::FUNC_W-1:0] func,
    input  wire logic [tfm_pkg::ID_W-1:0]   customer_id,
    input  wire logic [tfm_pkg::SEL_W-1:0]  line_select,
    input  wire logic [tfm_pkg::MODE_W-1:0] serve_mode,
    input  wire logic [tfm_pkg::CNT_W-1:0]  history_count,
    output logic                            cmd_valid,
    output tfm_pkg::cmd_t                   cmd,
    input  wire logic                       cmd_pop
);

    tfm_pkg::cmd_t                     cmd_in;
    tfm_pkg::cmd_t                     cmdq_mem [tfm_pkg::CMDQ_DEPTH];
    logic [tfm_pkg::CMDQ_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [tfm_pkg::CMDQ_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [tfm_pkg::CMDQ_CW-1:0]       count_reg, count_next;
    logic                              do_push;
    logic                              do_pop;

    // decode
    always_comb
    begin
        cmd_in.cid  = customer_id;
        cmd_in.sel  = line_select;
        cmd_in.mode = serve_mode;
        cmd_in.n    = (history_count > tfm_pkg::MAX_RESULTS) ? tfm_pkg::MAX_RESULTS
                                                             : history_count;
        unique case (func)
            tfm_pkg::FUNC_JOIN:  cmd_in.kind = tfm_pkg::K_JOIN;
            tfm_pkg::FUNC_SERVE: cmd_in.kind = tfm_pkg::K_SERVE;
            tfm_pkg::FUNC_HIST:  cmd_in.kind = tfm_pkg::K_HIST;
            tfm_pkg::FUNC_BAD:   cmd_in.kind = tfm_pkg::K_NONE;
            default:             cmd_in.kind = tfm_pkg::K_NONE;
        endcase
    end

    assign full      = (count_reg == tfm_pkg::CMDQ_CW'(tfm_pkg::CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == tfm_pkg::CMDQ_AW'(tfm_pkg::CMDQ_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tfm_pkg::CMDQ_AW'(tfm_pkg::CMDQ_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cmdq_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    assign cmd = cmdq_mem[rd_ptr_reg];

endmodule

`default_nettype wire

// File: sv/tfm_back.sv
// ----------------------------------------------------------------------------
// tfm_back: command execution
// Owns both entry queues, the service counter and the history stack, and
// emits result words into the result queue, holding while it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module tfm_back
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int HIST_DEPTH  = 32
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [tfm_pkg::CAP_W-1:0] line_capacity,
    input  wire logic                      cmd_valid,
    input  wire tfm_pkg::cmd_t             cmd,
    output logic                           cmd_pop,
    input  wire logic                      res_full,
    output logic                           res_push,
    output tfm_pkg::res_t                  res_data
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int HAW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int HFW = $clog2(HIST_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SERVE = 5'b00010,
        S_HRD   = 5'b00100,
        S_HWR   = 5'b01000,
        S_HEND  = 5'b10000
    } state_t;

    state_t                                state_reg, state_next;
    logic [tfm_pkg::ENTRY_W-1:0]           q_mem [2][QUEUE_DEPTH];
    logic [QAW-1:0]                        q_head_reg [2];
    logic [QAW-1:0]                        q_head_next [2];
    logic [QAW-1:0]                        q_tail_reg [2];
    logic [QAW-1:0]                        q_tail_next [2];
    logic [QCW-1:0]                        q_count_reg [2];
    logic [QCW-1:0]                        q_count_next [2];
    logic [tfm_pkg::STAMP_W-1:0]           svc_reg, svc_next;
    logic                                  alt_reg, alt_next;
    logic                                  pend_reg, pend_next;
    logic [tfm_pkg::CNT_W-1:0]             rem_reg, rem_next;
    logic [HAW-1:0]                        top_reg, top_next;
    logic [HFW-1:0]                        fill_reg, fill_next;

    logic [tfm_pkg::ENTRY_W-1:0]           hist_mem [HIST_DEPTH];
    logic [tfm_pkg::ENTRY_W-1:0]           hist_rdata_reg;
    logic                                  hist_we;
    logic                                  hist_re;
    logic [HAW-1:0]                        top_dec;
    logic [HAW-1:0]                        top_inc;

    logic                                  q_we;
    logic                                  q_wsel;
    logic [tfm_pkg::ENTRY_W-1:0]           q_wdata;

    logic [tfm_pkg::CAP_W-1:0]             cap;
    logic                                  join_sel;
    logic                                  join_ok;
    logic [tfm_pkg::STAMP_W-1:0]           join_stamp;
    logic [tfm_pkg::ENTRY_W-1:0]           head0;
    logic [tfm_pkg::ENTRY_W-1:0]           head1;
    logic                                  take;
    logic [tfm_pkg::ENTRY_W-1:0]           take_entry;
    logic [QCW:0]                          total;

    // effective capacity, saturated to the queue depth
    assign cap = (line_capacity > tfm_pkg::CAP_W'(QUEUE_DEPTH))
                 ? tfm_pkg::CAP_W'(QUEUE_DEPTH) : line_capacity;

    assign join_sel   = cmd.sel[1];
    assign join_ok    = ((cmd.sel == tfm_pkg::SEL_ONE) || (cmd.sel == tfm_pkg::SEL_TWO))
                        && (tfm_pkg::CAP_W'(q_count_reg[join_sel]) < cap);
    assign join_stamp = tfm_pkg::STAMP_W'(q_count_reg[0]) + tfm_pkg::STAMP_W'(q_count_reg[1])
                        + tfm_pkg::STAMP_W'(1);

    assign head0 = q_mem[0][q_head_reg[0]];
    assign head1 = q_mem[1][q_head_reg[1]];
    assign total = (QCW+1)'(q_count_reg[0]) + (QCW+1)'(q_count_reg[1]);

    // pick the queue to serve next; a pending second half of an
    // alternating pair always goes to queue two
    always_comb
    begin
        if (pend_reg || (q_count_reg[0] == '0))
        begin
            take = 1'b1;
        end
        else if (q_count_reg[1] == '0 || alt_reg)
        begin
            take = 1'b0;
        end
        else
        begin
            // stamp tie goes to queue two
            take = !(head0[tfm_pkg::STAMP_W-1:0] < head1[tfm_pkg::STAMP_W-1:0]);
        end
    end

    assign take_entry = take ? head1 : head0;

    assign top_dec = (top_reg == '0) ? HAW'(HIST_DEPTH - 1) : top_reg - 1'b1;
    assign top_inc = (top_reg == HAW'(HIST_DEPTH - 1)) ? '0 : top_reg + 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        q_head_next  = q_head_reg;
        q_tail_next  = q_tail_reg;
        q_count_next = q_count_reg;
        svc_next     = svc_reg;
        alt_next     = alt_reg;
        pend_next    = pend_reg;
        rem_next     = rem_reg;
        top_next     = top_reg;
        fill_next    = fill_reg;
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        res_data     = '{status: tfm_pkg::ST_NONE, id: '0, stamp: '0, last: 1'b1};
        hist_we      = 1'b0;
        hist_re      = 1'b0;
        q_we         = 1'b0;
        q_wsel       = join_sel;
        q_wdata      = {cmd.cid, join_stamp};

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !res_full)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        tfm_pkg::K_JOIN:
                        begin
                            res_push       = 1'b1;
                            res_data.id    = cmd.cid;
                            res_data.status = join_ok ? tfm_pkg::ST_JOINED
                                                      : tfm_pkg::ST_REJECT;
                            if (join_ok)
                            begin
                                q_we = 1'b1;
                                q_tail_next[join_sel] =
                                    (q_tail_reg[join_sel] == QAW'(QUEUE_DEPTH - 1))
                                    ? '0 : q_tail_reg[join_sel] + 1'b1;
                                q_count_next[join_sel] = q_count_reg[join_sel] + 1'b1;
                            end
                        end
                        tfm_pkg::K_SERVE:
                        begin
                            if ((cmd.mode == tfm_pkg::MODE_MERGE) ||
                                (cmd.mode == tfm_pkg::MODE_ALT))
                            begin
                                svc_next  = '0;
                                alt_next  = (cmd.mode == tfm_pkg::MODE_ALT);
                                pend_next = 1'b0;
                                if (total == '0)
                                begin
                                    res_push = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_SERVE;
                                end
                            end
                            else
                            begin
                                res_push = 1'b1;
                            end
                        end
                        tfm_pkg::K_HIST:
                        begin
                            if (cmd.n == '0 || fill_reg == '0)
                            begin
                                res_push = 1'b1;
                            end
                            else
                            begin
                                rem_next   = cmd.n;
                                state_next = S_HRD;
                            end
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end

            S_SERVE:
            begin
                if (!res_full)
                begin
                    res_push       = 1'b1;
                    res_data.status = tfm_pkg::ST_SERVED;
                    res_data.id    = take_entry[tfm_pkg::ENTRY_W-1:tfm_pkg::STAMP_W];
                    res_data.stamp = svc_reg;
                    res_data.last  = (total == (QCW+1)'(1));
                    q_head_next[take] = (q_head_reg[take] == QAW'(QUEUE_DEPTH - 1))
                                        ? '0 : q_head_reg[take] + 1'b1;
                    q_count_next[take] = q_count_reg[take] - 1'b1;
                    svc_next  = svc_reg + 1'b1;
                    pend_next = alt_reg && !pend_reg && !take && (q_count_reg[1] != '0);
                    hist_we   = 1'b1;
                    top_next  = top_inc;
                    if (fill_reg != HFW'(HIST_DEPTH))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    if (total == (QCW+1)'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_HRD:
            begin
                hist_re    = 1'b1;
                top_next   = top_dec;
                fill_next  = fill_reg - 1'b1;
                rem_next   = rem_reg - 1'b1;
                state_next = S_HWR;
            end

            S_HWR:
            begin
                if (!res_full)
                begin
                    res_push       = 1'b1;
                    res_data.status = tfm_pkg::ST_HIST;
                    res_data.id    = hist_rdata_reg[tfm_pkg::ENTRY_W-1:tfm_pkg::STAMP_W];
                    res_data.stamp = hist_rdata_reg[tfm_pkg::STAMP_W-1:0];
                    res_data.last  = (rem_reg == '0);
                    if (rem_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (fill_reg == '0)
                    begin
                        state_next = S_HEND;
                    end
                    else
                    begin
                        state_next = S_HRD;
                    end
                end
            end

            S_HEND:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            q_head_reg  <= '{default: '0};
            q_tail_reg  <= '{default: '0};
            q_count_reg <= '{default: '0};
            svc_reg     <= '0;
            alt_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            rem_reg     <= '0;
            top_reg     <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            q_head_reg  <= q_head_next;
            q_tail_reg  <= q_tail_next;
            q_count_reg <= q_count_next;
            svc_reg     <= svc_next;
            alt_reg     <= alt_next;
            pend_reg    <= pend_next;
            rem_reg     <= rem_next;
            top_reg     <= top_next;
            fill_reg    <= fill_next;
        end
    end

    // entry queues
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_wsel][q_tail_reg[q_wsel]] <= q_wdata;
        end
    end

    // history stack, registered read
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[top_reg] <= {take_entry[tfm_pkg::ENTRY_W-1:tfm_pkg::STAMP_W], svc_reg};
        end
        if (hist_re)
        begin
            hist_rdata_reg <= hist_mem[top_dec];
        end
    end

endmodule

`default_nettype wire

// File: sv/tfm_resq.sv
// ----------------------------------------------------------------------------
// tfm_resq: result queue
// Small FIFO of result words between the execution side and the output ports.
// ----------------------------------------------------------------------------
`default_nettype none

module tfm_resq
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire tfm_pkg::res_t wdata,
    output logic               full,
    output logic               empty,
    input  wire logic          pop,
    output tfm_pkg::res_t      rdata
);

    tfm_pkg::res_t                 mem [tfm_pkg::RESQ_DEPTH];
    logic [tfm_pkg::RESQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [tfm_pkg::RESQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [tfm_pkg::RESQ_CW-1:0]   count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full    = (count_reg == tfm_pkg::RESQ_CW'(tfm_pkg::RESQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == tfm_pkg::RESQ_AW'(tfm_pkg::RESQ_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tfm_pkg::RESQ_AW'(tfm_pkg::RESQ_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem[rd_ptr_reg];

endmodule

`default_nettype wire
